>>> src/xdar_pkg.sv
package xdar_pkg;

    // Default fraction bits of the sine table
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // Angle constants in whole degrees
    localparam int SHIFT_DEG = 45;
    localparam int QUARTER   = 90;
    localparam int HALF_TURN = 180;
    localparam int FULL_TURN = 360;

    // Drive value width and quotient width (quotient magnitude stays below 256)
    localparam int DW = 9;
    localparam int QW = 8;

    // Table index width: entries 0..90
    localparam int IDXW = 7;

    // pi in Q30 and the Taylor series divisors (2n)(2n+1)
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Angle stage result: table indexes and signs of the trig terms
    typedef struct packed {
        logic                 special;
        logic                 s_neg;
        logic                 c_neg;
        logic [IDXW-1:0]      sidx;
        logic [IDXW-1:0]      cidx;
        logic signed [DW-1:0] mag;
    } ang_t;

    // Trig stage side band
    typedef struct packed {
        logic                 special;
        logic                 s_neg;
        logic                 c_neg;
        logic signed [DW-1:0] mag;
    } trg_t;

    // Side band through the divider
    typedef struct packed {
        logic                 special;
        logic                 left_dom;
        logic                 right_dom;
        logic                 s_neg;
        logic                 c_neg;
        logic                 q_neg;
        logic signed [DW-1:0] mag;
    } side_t;

    // sin(k degrees), k in 0..90, unsigned with frac fraction bits, evaluated at elaboration
    function automatic longint unsigned sin_q(input int k, input int frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned s;
        x    = (longint'(k) * PI_Q30) / 180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(term);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        s = longint'(sum);
        return ((s >> (29 - frac)) + 64'd1) >> 1;
    endfunction

endpackage

>>> src/xdar_angle.sv
module xdar_angle
    import xdar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] magnitude,
    input  logic signed [DW-1:0] heading_deg,
    output logic                 out_valid,
    output ang_t                 ang
);

    logic       valid_reg;
    ang_t       ang_reg;
    ang_t       ang_next;
    logic [9:0] shifted;
    logic [9:0] wrapped;
    logic [8:0] d;

    // Shift by 45 degrees, wrap negatives into 0..359
    always_comb
    begin
        shifted = {heading_deg[DW-1], heading_deg} + 10'(SHIFT_DEG);
        wrapped = shifted[9] ? (shifted + 10'(FULL_TURN)) : shifted;
        d       = wrapped[8:0];
    end

    // Quadrant folding onto the first-quadrant table
    always_comb
    begin
        ang_next.special = (shifted == 10'd0) || (shifted == 10'(HALF_TURN));
        ang_next.mag     = magnitude;
        if (d <= 9'(QUARTER))
        begin
            ang_next.sidx  = IDXW'(d);
            ang_next.cidx  = IDXW'(9'(QUARTER) - d);
            ang_next.s_neg = 1'b0;
            ang_next.c_neg = 1'b0;
        end
        else if (d <= 9'(HALF_TURN))
        begin
            ang_next.sidx  = IDXW'(9'(HALF_TURN) - d);
            ang_next.cidx  = IDXW'(d - 9'(QUARTER));
            ang_next.s_neg = 1'b0;
            ang_next.c_neg = 1'b1;
        end
        else if (d <= 9'(HALF_TURN + QUARTER))
        begin
            ang_next.sidx  = IDXW'(d - 9'(HALF_TURN));
            ang_next.cidx  = IDXW'(9'(HALF_TURN + QUARTER) - d);
            ang_next.s_neg = 1'b1;
            ang_next.c_neg = 1'b1;
        end
        else
        begin
            ang_next.sidx  = IDXW'(9'(FULL_TURN) - d);
            ang_next.cidx  = IDXW'(d - 9'(HALF_TURN + QUARTER));
            ang_next.s_neg = 1'b1;
            ang_next.c_neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    assign out_valid = valid_reg;
    assign ang       = ang_reg;

endmodule

>>> src/xdar_trig.sv
module xdar_trig
    import xdar_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  ang_t                    ang,
    output logic                    out_valid,
    output trg_t                    trg,
    output logic [TRIG_FRAC_BITS:0] s_abs,
    output logic [TRIG_FRAC_BITS:0] c_abs
);

    localparam int TW = TRIG_FRAC_BITS + 1;

    logic [TW-1:0] sin_tab [0:QUARTER];
    logic          valid_reg;
    trg_t          trg_reg;
    logic [TW-1:0] s_abs_reg;
    logic [TW-1:0] c_abs_reg;

    // Constant quarter-wave sine table
    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_tab
        assign sin_tab[k] = TW'(sin_q(k, TRIG_FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Two table reads, side band follows
    always_ff @(posedge clk)
    begin
        s_abs_reg       <= sin_tab[ang.sidx];
        c_abs_reg       <= sin_tab[ang.cidx];
        trg_reg.special <= ang.special;
        trg_reg.s_neg   <= ang.s_neg;
        trg_reg.c_neg   <= ang.c_neg;
        trg_reg.mag     <= ang.mag;
    end

    assign out_valid = valid_reg;
    assign trg       = trg_reg;
    assign s_abs     = s_abs_reg;
    assign c_abs     = c_abs_reg;

endmodule

>>> src/xdar_div.sv
module xdar_div
    import xdar_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  side_t                   side_in,
    input  logic [DW-1:0]           r_abs,
    input  logic [TRIG_FRAC_BITS:0] own,
    input  logic [TRIG_FRAC_BITS:0] other,
    output logic                    out_valid,
    output side_t                   side_out,
    output logic [QW-1:0]           quot
);

    localparam int TW = TRIG_FRAC_BITS + 1;
    localparam int PW = TW + DW;

    logic          valid_reg [0:QW];
    side_t         side_reg  [0:QW];
    logic [PW-1:0] rem_reg   [0:QW];
    logic [TW-1:0] den_reg   [0:QW];
    logic [QW-1:0] quo_reg   [0:QW];

    // Product stage: |r| * |own term|
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= PW'(r_abs) * PW'(own);
        den_reg[0]  <= other;
        side_reg[0] <= side_in;
        quo_reg[0]  <= '0;
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [PW-1:0] den_shift;
        logic [PW:0]   trial;
        logic          fits;
        logic [PW-1:0] rem_next;

        assign den_shift = PW'(den_reg[i]) << (QW - 1 - i);
        assign trial     = {1'b0, rem_reg[i]} - {1'b0, den_shift};
        assign fits      = !trial[PW];
        assign rem_next  = fits ? trial[PW-1:0] : rem_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= rem_next;
            den_reg[i+1]  <= den_reg[i];
            side_reg[i+1] <= side_reg[i];
            quo_reg[i+1]  <= {quo_reg[i][QW-2:0], fits};
        end
    end

    assign out_valid = valid_reg[QW];
    assign side_out  = side_reg[QW];
    assign quot      = quo_reg[QW];

endmodule

>>> src/xdrive_angle_remap.sv
// X-drive wheel-pair mixer: heading + 45 deg, sine/cosine table, one shared divider.
// Pipeline from the accepted command to the done strobe: angle fold, table read,
// term select, product, 8 divider stages, output.
// Throughput: one command per cycle; busy is always low, the pipeline never stalls
// and the receiver takes each result in the single cycle that done is high.
// Reset: rst_n (async, active low) clears all valid bits; no result is in flight.
module xdrive_angle_remap
    import xdar_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [DW-1:0] magnitude,
    input  logic signed [DW-1:0] heading_deg,
    output logic                 done,
    output logic signed [DW-1:0] left_drive,
    output logic signed [DW-1:0] right_drive
);

    localparam int TW = TRIG_FRAC_BITS + 1;

    logic          ang_valid;
    ang_t          ang;
    logic          trg_valid;
    trg_t          trg;
    logic [TW-1:0] s_abs;
    logic [TW-1:0] c_abs;

    logic          sel_valid_reg;
    side_t         sel_side_reg;
    side_t         sel_side_next;
    logic [DW-1:0] r_abs_reg;
    logic [TW-1:0] own_reg;
    logic [TW-1:0] other_reg;

    logic          div_valid;
    side_t         div_side;
    logic [QW-1:0] quot;

    logic          done_reg;
    logic [DW-1:0] left_reg;
    logic [DW-1:0] right_reg;
    logic [DW-1:0] left_next;
    logic [DW-1:0] right_next;
    logic [DW-1:0] q_val;

    // Negate on request, saturating +256 to +255
    function automatic logic [DW-1:0] apply_sign(input logic [DW-1:0] r, input logic neg);
        logic [DW:0] wide;
        wide = neg ? (~{r[DW-1], r} + 1'b1) : {r[DW-1], r};
        if (wide == (DW+1)'(1 << (DW-1)))
        begin
            return {1'b0, {(DW-1){1'b1}}};
        end
        return wide[DW-1:0];
    endfunction

    assign busy = 1'b0;

    xdar_angle u_angle
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .magnitude   (magnitude),
        .heading_deg (heading_deg),
        .out_valid   (ang_valid),
        .ang         (ang)
    );

    xdar_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .ang       (ang),
        .out_valid (trg_valid),
        .trg       (trg),
        .s_abs     (s_abs),
        .c_abs     (c_abs)
    );

    // Dominance compare, pick the dominated side's terms for the divider
    always_comb
    begin
        sel_side_next.special   = trg.special;
        sel_side_next.left_dom  = (c_abs >= s_abs);
        sel_side_next.right_dom = (s_abs >= c_abs);
        sel_side_next.s_neg     = trg.s_neg;
        sel_side_next.c_neg     = trg.c_neg;
        sel_side_next.mag       = trg.mag;
        // left dominant means right is divided: own term is sine
        sel_side_next.q_neg     = trg.mag[DW-1] ^ (sel_side_next.left_dom ? trg.s_neg
                                                                           : trg.c_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg <= trg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_side_reg <= sel_side_next;
        r_abs_reg    <= trg.mag[DW-1] ? (~trg.mag + 1'b1) : trg.mag;
        own_reg      <= sel_side_next.left_dom ? s_abs : c_abs;
        other_reg    <= sel_side_next.left_dom ? c_abs : s_abs;
    end

    xdar_div #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid_reg),
        .side_in   (sel_side_reg),
        .r_abs     (r_abs_reg),
        .own       (own_reg),
        .other     (other_reg),
        .out_valid (div_valid),
        .side_out  (div_side),
        .quot      (quot)
    );

    // Output compose: magnitude on both sides, dominant sign, or signed quotient
    always_comb
    begin
        q_val = div_side.q_neg ? (~{1'b0, quot} + 1'b1) : {1'b0, quot};
        if (div_side.special)
        begin
            left_next  = div_side.mag;
            right_next = div_side.mag;
        end
        else
        begin
            left_next  = div_side.left_dom ? apply_sign(div_side.mag, div_side.c_neg) : q_val;
            right_next = div_side.right_dom ? apply_sign(div_side.mag, div_side.s_neg) : q_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign done        = done_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule

>>> bench/xdrive_angle_remap_check.sv
`timescale 1ns / 100ps

// Watches the command and result ports, predicts each wheel-pair result
// and compares the results in order of arrival.
module xdrive_angle_remap_check
    import xdar_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [DW-1:0] magnitude,
    input  logic signed [DW-1:0] heading_deg,
    input  logic                 done,
    input  logic signed [DW-1:0] left_drive,
    input  logic signed [DW-1:0] right_drive,
    output int                   fails,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        logic signed [DW-1:0] left_val;
        logic signed [DW-1:0] right_val;
    } wheel_pair_t;

    // sin(k deg) for k = 0..90, 1.0 = 2^TRIG_FRAC_BITS
    longint      sine_q [0:QUARTER];
    wheel_pair_t wheel_q [$];

    // Q30 Taylor series, then round half up to the table precision
    function automatic longint sine_entry(input int k);
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned term;
        longint unsigned s;
        longint          acc;
        rad    = (longint'(k) * PI_Q30) / 64'd180;
        rad_sq = (rad * rad) >> 30;
        term   = rad;
        acc    = longint'(rad);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * rad_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        s = acc;
        return longint'(((s >> (29 - TRIG_FRAC_BITS)) + 64'd1) >> 1);
    endfunction

    // Quadrant fold of a reduced angle in 0..359
    function automatic void fold_trig(input longint d, output longint sn, output longint cs);
        if (d <= QUARTER)
        begin
            sn = sine_q[d];
            cs = sine_q[QUARTER - d];
        end
        else if (d <= HALF_TURN)
        begin
            sn = sine_q[HALF_TURN - d];
            cs = -sine_q[d - QUARTER];
        end
        else if (d <= HALF_TURN + QUARTER)
        begin
            sn = -sine_q[d - HALF_TURN];
            cs = -sine_q[HALF_TURN + QUARTER - d];
        end
        else
        begin
            sn = -sine_q[FULL_TURN - d];
            cs = sine_q[d - HALF_TURN - QUARTER];
        end
    endfunction

    // Only +256 can overflow the 9-bit result
    function automatic logic signed [DW-1:0] clamp_drive(input longint v);
        if (v > 255)
        begin
            v = 255;
        end
        if (v < -256)
        begin
            v = -256;
        end
        return v[DW-1:0];
    endfunction

    // Dominant side takes the signed magnitude, the other side the ratio
    function automatic logic signed [DW-1:0] wheel_share(input longint r, input longint own,
                                                         input longint other);
        longint own_abs;
        longint other_abs;
        longint v;
        own_abs   = (own < 0) ? -own : own;
        other_abs = (other < 0) ? -other : other;
        if (own_abs >= other_abs)
        begin
            if (own > 0)
            begin
                v = r;
            end
            else if (own < 0)
            begin
                v = -r;
            end
            else
            begin
                v = 0;
            end
        end
        else
        begin
            v = (r * own) / other_abs;
        end
        return clamp_drive(v);
    endfunction

    function automatic wheel_pair_t wheel_mix(input logic signed [DW-1:0] mag,
                                              input logic signed [DW-1:0] hdg);
        longint      r;
        longint      shifted;
        longint      d;
        longint      sn;
        longint      cs;
        wheel_pair_t res;
        r       = mag;
        shifted = longint'(hdg) + SHIFT_DEG;
        // straight along an axis: both pairs run at the magnitude
        if (shifted == 0 || shifted == HALF_TURN)
        begin
            res.left_val  = clamp_drive(r);
            res.right_val = clamp_drive(r);
        end
        else
        begin
            d = ((shifted % FULL_TURN) + FULL_TURN) % FULL_TURN;
            fold_trig(d, sn, cs);
            res.left_val  = wheel_share(r, cs, sn);
            res.right_val = wheel_share(r, sn, cs);
        end
        return res;
    endfunction

    initial
    begin
        fails   = 0;
        pending = 0;
        checked = 0;
        for (int k = 0; k <= QUARTER; k++)
        begin
            sine_q[k] = sine_entry(k);
        end
    end

    // Result compare first, then queue the command taken at this edge
    always @(posedge clk)
    begin
        wheel_pair_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (wheel_q.size() == 0)
                begin
                    fails++;
                    $error("result with no command waiting: left_drive %0d, right_drive %0d",
                           left_drive, right_drive);
                end
                else
                begin
                    want = wheel_q.pop_front();
                    checked++;
                    if (left_drive !== want.left_val)
                    begin
                        fails++;
                        $error("left_drive: expected %0d, got %0d", want.left_val, left_drive);
                    end
                    if (right_drive !== want.right_val)
                    begin
                        fails++;
                        $error("right_drive: expected %0d, got %0d", want.right_val,
                               right_drive);
                    end
                end
            end
            if (start && !busy)
            begin
                wheel_q.push_back(wheel_mix(magnitude, heading_deg));
            end
            pending = wheel_q.size();
        end
    end

endmodule

>>> bench/xdrive_angle_remap_test.sv
`timescale 1ns / 100ps

// Command stimulus and verdict for the X-drive wheel-pair mixer.
module xdrive_angle_remap_test
    import xdar_pkg::*;
();

    localparam int FRAC        = TRIG_FRAC_BITS_DEF;
    localparam int RAND_CMDS   = 1850;
    localparam int QUIET_TAIL  = 300;
    localparam int TAIL_CYCLES = 30;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic signed [DW-1:0] magnitude   = '0;
    logic signed [DW-1:0] heading_deg = '0;
    logic                 busy;
    logic                 done;
    logic signed [DW-1:0] left_drive;
    logic signed [DW-1:0] right_drive;

    int fails;
    int pending;
    int checked;
    int sent   = 0;
    int cycles = 0;
    int n_dir;

    always #6 clk = ~clk;

    xdrive_angle_remap #(
        .TRIG_FRAC_BITS(FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .magnitude  (magnitude),
        .heading_deg(heading_deg),
        .done       (done),
        .left_drive (left_drive),
        .right_drive(right_drive)
    );

    xdrive_angle_remap_check #(
        .TRIG_FRAC_BITS(FRAC)
    ) check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .magnitude  (magnitude),
        .heading_deg(heading_deg),
        .done       (done),
        .left_drive (left_drive),
        .right_drive(right_drive),
        .fails      (fails),
        .pending    (pending),
        .checked    (checked)
    );

    // Run-away guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** xdrive_angle_remap: FAILED **");
            $finish;
        end
    end

    // Start stays high across back-to-back transfers
    task automatic send_cmd(input int m, input int h);
        start       <= 1'b1;
        magnitude   <= m[DW-1:0];
        heading_deg <= h[DW-1:0];
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every queued result has come back
    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic maybe_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            idle_for($urandom_range(1, 18));
        end
    endtask

    initial
    begin
        int  m;
        int  h;
        bit  gaps;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sign extremes, axis cases, wrap of the shifted angle, ties
        send_cmd(0, 0);
        send_cmd(200, 0);        // 45 deg: sine and cosine tie
        send_cmd(-200, -180);
        maybe_gap(1);
        send_cmd(200, 180);      // 225 deg tie, both negative
        send_cmd(-200, -45);     // shifted 0: both take the magnitude
        send_cmd(200, 135);      // shifted 180
        send_cmd(255, -45);
        send_cmd(-256, 135);
        maybe_gap(1);
        send_cmd(-256, 225);     // times -1 saturates to +255
        send_cmd(-256, -135);
        send_cmd(150, 45);       // cosine is zero on the dominated side
        send_cmd(150, -225);     // shifted -180 follows the normal rule
        send_cmd(150, 315);      // 315 wraps to -197 in nine bits
        send_cmd(-1, -256);
        send_cmd(255, 255);
        maybe_gap(1);
        send_cmd(-256, -256);
        send_cmd(1, 10);
        send_cmd(-1, 100);
        send_cmd(-200, -90);
        send_cmd(200, 30);
        send_cmd(77, -170);
        n_dir = sent;
        drain();

        // Random commands, mostly in range, with axis and tie headings mixed in
        for (int i = 0; i < RAND_CMDS; i++)
        begin
            gaps = (i < RAND_CMDS - QUIET_TAIL);
            case ($urandom_range(0, 9))
                0:
                begin
                    m = int'($urandom_range(0, 511));
                    h = int'($urandom_range(0, 511));
                end
                1:
                begin
                    m = int'($urandom_range(0, 511));
                    case ($urandom_range(0, 3))
                        0: h = -45;
                        1: h = 135;
                        2: h = -225;
                        default: h = 315;
                    endcase
                end
                2:
                begin
                    m = int'($urandom_range(0, 400)) - 200;
                    h = 45 * int'($urandom_range(0, 8)) - 225;
                end
                default:
                begin
                    m = int'($urandom_range(0, 400)) - 200;
                    h = int'($urandom_range(0, 360)) - 180;
                end
            endcase
            maybe_gap(gaps);
            send_cmd(m, h);
            if (i == RAND_CMDS / 2)
            begin
                drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d commands (%0d directed at axis, wrap, tie and saturation cases),",
                 sent, n_dir);
        $display("full 9-bit headings and magnitudes; %0d results compared.", checked);
        if (fails == 0)
        begin
            $display("** xdrive_angle_remap: PASSED **");
        end
        else
        begin
            $display("** xdrive_angle_remap: FAILED **");
        end
        $finish;
    end

endmodule
